/* design/ssfd_pkg.sv */
package ssfd_pkg;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned BYTE_W   = 8;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned CNT_W  = QPTR_W + 1;

  localparam int unsigned COEF_W      = 14;
  localparam int unsigned PROD_W      = SAMPLE_W + COEF_W;
  localparam int unsigned RECIP_W     = 27;
  localparam int unsigned RECIP_SHIFT = 36;
  localparam int unsigned WIDE_W      = PROD_W + RECIP_W;
  localparam int unsigned QUOT_W      = 13;
  localparam int unsigned DIV_W       = 14;
  localparam int unsigned BACK_W      = QUOT_W + DIV_W;
  localparam int unsigned REM_W       = 15;
  localparam int unsigned VALUE_W     = 11;
  localparam int unsigned REM1K_W     = 10;

  localparam logic [SAMPLE_W-1:0] THR_RESET = 12'd10;

  localparam logic [SAMPLE_W-1:0] X_LOW_MAX  = 12'd49;
  localparam logic [SAMPLE_W-1:0] X_MID_END  = 12'd1400;
  localparam logic [SAMPLE_W-1:0] X_HIGH_MAX = 12'd4030;
  localparam logic [SAMPLE_W-1:0] X_TOP_MAX  = 12'd4090;

  localparam logic [COEF_W-1:0] COEF_LOW  = 14'd386;
  localparam logic [COEF_W-1:0] COEF_MID  = 14'd381;
  localparam logic [COEF_W-1:0] COEF_HIGH = 14'd4198;
  localparam logic [COEF_W-1:0] COEF_TOP  = 14'd10274;

  localparam logic [DIV_W-1:0] DIV_1K  = 14'd1000;
  localparam logic [DIV_W-1:0] DIV_10K = 14'd10000;

  // floor(2^RECIP_SHIFT / divisor)
  localparam logic [RECIP_W-1:0] RECIP_1K  = 27'd68719476;
  localparam logic [RECIP_W-1:0] RECIP_10K = 27'd6871947;

  localparam logic [QUOT_W-1:0] OFS_MID  = 13'd205;
  localparam logic [QUOT_W-1:0] OFS_HIGH = 13'd156;
  localparam logic [QUOT_W-1:0] OFS_TOP  = 13'd2207;
  localparam logic [VALUE_W-1:0] VAL_SAT = 11'd2000;

  localparam logic [VALUE_W-1:0] VAL_1K = 11'd1000;
  localparam logic [VALUE_W-1:0] VAL_2K = 11'd2000;

  localparam logic [BYTE_W-1:0] BYTE_STX  = 8'h02;
  localparam logic [BYTE_W-1:0] BYTE_DOT  = 8'h2E;
  localparam logic [BYTE_W-1:0] BYTE_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] BYTE_ETX  = 8'h03;
  localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h30;

  typedef enum logic [2:0] {
    SEG_LOW,
    SEG_MID,
    SEG_HIGH,
    SEG_TOP,
    SEG_SAT
  } ssfd_seg_e;

  typedef enum logic [2:0] {
    POS_STX,
    POS_THOU,
    POS_DOT,
    POS_HUND,
    POS_TENS,
    POS_ONES,
    POS_CR,
    POS_ETX
  } ssfd_pos_e;

  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] value;
  } ssfd_push_t;

  typedef struct packed {
    logic               valid;
    logic               full;
    logic [VALUE_W-1:0] value;
  } ssfd_head_t;

endpackage

/* design/ssfd_front.sv */
module ssfd_front import ssfd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic                cfg_we_i,
  input  logic [SAMPLE_W-1:0] cfg_wdata_i,
  input  logic                pop_i,
  output ssfd_push_t          push_o
);

  logic [CNT_W-1:0]    count_q, count_d;
  logic [SAMPLE_W-1:0] thr_q, held_q, held_d, diff;
  logic                accept;

  logic                val_a_q, val_b_q, val_c_q, val_d_q;
  ssfd_seg_e           seg_d, seg_b_q, seg_c_q, seg_d_q;
  logic [COEF_W-1:0]   coef;
  logic [PROD_W-1:0]   prod_b_q, prod_c_q;
  logic [RECIP_W-1:0]  recip;
  logic [WIDE_W-1:0]   wide;
  logic [QUOT_W-1:0]   qest_c_q, qest_d_q, quot;
  logic [DIV_W-1:0]    div_c, div_d;
  logic [BACK_W-1:0]   back;
  logic [REM_W-1:0]    rem_d_q;
  logic [VALUE_W-1:0]  value;

  assign in_ready_o = count_q < CNT_W'(QDEPTH);
  assign accept     = in_valid_i && in_ready_o;
  assign count_d    = count_q + CNT_W'(accept) - CNT_W'(pop_i);

  assign diff   = (sample_i >= held_q) ? (sample_i - held_q) : (held_q - sample_i);
  assign held_d = (accept && (diff > thr_q)) ? sample_i : held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      thr_q   <= THR_RESET;
      held_q  <= '0;
      val_a_q <= 1'b0;
      val_b_q <= 1'b0;
      val_c_q <= 1'b0;
      val_d_q <= 1'b0;
    end else begin
      count_q <= count_d;
      held_q  <= held_d;
      val_a_q <= accept;
      val_b_q <= val_a_q;
      val_c_q <= val_b_q;
      val_d_q <= val_c_q;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  always_comb begin
    if (held_q != '0 && held_q <= X_LOW_MAX) begin
      seg_d = SEG_LOW;
    end else if (held_q < X_MID_END) begin
      seg_d = SEG_MID;
    end else if (held_q <= X_HIGH_MAX) begin
      seg_d = SEG_HIGH;
    end else if (held_q <= X_TOP_MAX) begin
      seg_d = SEG_TOP;
    end else begin
      seg_d = SEG_SAT;
    end
    case (seg_d)
      SEG_LOW:  coef = COEF_LOW;
      SEG_MID:  coef = COEF_MID;
      SEG_HIGH: coef = COEF_HIGH;
      SEG_TOP:  coef = COEF_TOP;
      default:  coef = '0;
    endcase
  end

  assign recip = (seg_b_q == SEG_MID) ? RECIP_1K : RECIP_10K;
  assign wide  = WIDE_W'(prod_b_q) * WIDE_W'(recip);
  assign div_c = (seg_c_q == SEG_MID) ? DIV_1K : DIV_10K;
  assign back  = BACK_W'(qest_c_q) * BACK_W'(div_c);
  assign div_d = (seg_d_q == SEG_MID) ? DIV_1K : DIV_10K;

  always_ff @(posedge clk_i) begin
    seg_b_q  <= seg_d;
    prod_b_q <= PROD_W'(held_q) * PROD_W'(coef);
    seg_c_q  <= seg_b_q;
    prod_c_q <= prod_b_q;
    qest_c_q <= wide[RECIP_SHIFT +: QUOT_W];
    seg_d_q  <= seg_c_q;
    qest_d_q <= qest_c_q;
    rem_d_q  <= REM_W'(BACK_W'(prod_c_q) - back);
  end

  // correct the reciprocal estimate by one, then offset per segment
  always_comb begin
    quot = qest_d_q + QUOT_W'(rem_d_q >= REM_W'(div_d));
    case (seg_d_q)
      SEG_LOW:  value = VALUE_W'(quot);
      SEG_MID:  value = VALUE_W'(quot + OFS_MID);
      SEG_HIGH: value = VALUE_W'(quot + OFS_HIGH);
      SEG_TOP:  value = VALUE_W'(quot - OFS_TOP);
      default:  value = VAL_SAT;
    endcase
  end

  assign push_o.valid = val_d_q;
  assign push_o.value = value;

endmodule

/* design/ssfd_queue.sv */
module ssfd_queue import ssfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ssfd_push_t push_i,
  input  logic       pop_i,
  output ssfd_head_t head_o
);

  logic [VALUE_W-1:0] mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      fill_q <= fill_q + CNT_W'(push_i.valid) - CNT_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.value;
    end
  end

  assign head_o.valid = fill_q != '0;
  assign head_o.full  = fill_q == CNT_W'(QDEPTH);
  assign head_o.value = mem_q[rd_ptr_q];

endmodule

/* design/ssfd_back.sv */
module ssfd_back import ssfd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ssfd_head_t        head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              last_byte_o
);

  logic              active_q, out_valid_q, last_q, load;
  ssfd_pos_e         pos_q;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic [1:0]        thou_q, thou_d;
  logic [REM1K_W-1:0] rem_q, rem_d;
  logic [3:0]        hund_q, tens_q, ones_q;
  logic [6:0]        rem100_q;
  logic [15:0]       hund_prod;
  logic [14:0]       tens_prod;

  assign load  = !out_valid_q || out_ready_i;
  assign pop_o = head_i.valid && (!active_q || (load && pos_q == POS_ETX));

  always_comb begin
    if (head_i.value >= VAL_2K) begin
      thou_d = 2'd2;
      rem_d  = REM1K_W'(head_i.value - VAL_2K);
    end else if (head_i.value >= VAL_1K) begin
      thou_d = 2'd1;
      rem_d  = REM1K_W'(head_i.value - VAL_1K);
    end else begin
      thou_d = 2'd0;
      rem_d  = REM1K_W'(head_i.value);
    end
  end

  assign hund_prod = 16'(rem_q) * 16'd41;
  assign tens_prod = 15'(rem100_q) * 15'd205;

  always_comb begin
    case (pos_q)
      POS_STX:  byte_d = BYTE_STX;
      POS_THOU: byte_d = BYTE_ZERO + BYTE_W'(thou_q);
      POS_DOT:  byte_d = BYTE_DOT;
      POS_HUND: byte_d = BYTE_ZERO + BYTE_W'(hund_q);
      POS_TENS: byte_d = BYTE_ZERO + BYTE_W'(tens_q);
      POS_ONES: byte_d = BYTE_ZERO + BYTE_W'(ones_q);
      POS_CR:   byte_d = BYTE_CR;
      default:  byte_d = BYTE_ETX;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      pos_q       <= POS_STX;
    end else begin
      if (load) begin
        out_valid_q <= active_q;
        last_q      <= active_q && (pos_q == POS_ETX);
        if (active_q) begin
          pos_q <= ssfd_pos_e'(pos_q + 3'd1);
          if (pos_q == POS_ETX) begin
            active_q <= 1'b0;
          end
        end
      end
      if (pop_o) begin
        active_q <= 1'b1;
        pos_q    <= POS_STX;
      end
    end
  end

  // digits settle in registered steps after a pop, ahead of their byte slots
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      thou_q <= thou_d;
      rem_q  <= rem_d;
    end
    if (load && active_q) begin
      byte_q <= byte_d;
    end
    hund_q   <= hund_prod[15:12];
    rem100_q <= 7'(rem_q - REM1K_W'(hund_q) * REM1K_W'(100));
    tens_q   <= tens_prod[14:11];
    ones_q   <= 4'(rem100_q - 7'(tens_q) * 7'd10);
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = byte_q;
  assign last_byte_o = last_q;

endmodule

/* design/sensor_sample_to_framed_decimal.sv */
// Sensor sample to framed decimal message.
// Input channel (in_valid_i/in_ready_o, sample_i): one 12-bit ADC word per
// item. A sample that differs from the held sample by more than the change
// threshold replaces it; the held sample is calibrated to 0..2000.
// Output channel (out_valid_o/out_ready_i, out_byte_o, last_byte_o): each
// input word yields eight byte words: STX, thousands, '.', hundreds, tens,
// ones, CR, ETX, with last_byte_o high on ETX.
// Configuration: cfg_we_i writes cfg_wdata_i to the change threshold;
// write it only while the block is idle.
// Path: an accepted sample passes the held register, the calibration
// stages, the queue and the byte register before its STX byte is valid.
// Throughput: the serializer takes the next sample as it loads the ETX
// byte of the current one; the calibration pipeline takes a sample each
// cycle while in_ready_o is high; up to four samples wait for serializing.
// Stall: a stalled receiver holds the current byte; the input stops taking
// words once four samples are waiting.
// Reset: threshold 10, held sample 0, no byte pending.
module sensor_sample_to_framed_decimal import ssfd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic                cfg_we_i,
  input  logic [SAMPLE_W-1:0] cfg_wdata_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [BYTE_W-1:0]   out_byte_o,
  output logic                last_byte_o
);

  ssfd_push_t push;
  ssfd_head_t head;
  logic       pop;

  ssfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sample_i   (sample_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .pop_i      (pop),
    .push_o     (push)
  );

  ssfd_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .pop_i (pop),
    .head_o(head)
  );

  ssfd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_byte_o (out_byte_o),
    .last_byte_o(last_byte_o)
  );

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> !head.full)
    else $error("push into full queue");

  a_pop_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid)
    else $error("pop from empty queue");

  a_last_is_etx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_byte_o) |-> (out_byte_o == BYTE_ETX))
    else $error("last byte is not ETX");

  a_frame_starts_stx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_byte_o) |=>
      (!out_valid_o || out_byte_o == BYTE_STX))
    else $error("frame does not open with STX");

endmodule
